// File: rtl/core/swa_pkg.sv
// shared types and constants for the sliding window autoscale core
// no dependencies; imported by every module of the core but swa_ram
`timescale 1ns / 1ps
`default_nettype none
package swa_pkg;

	localparam int WINDOW_DEPTH = 80;
	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int FIELD_W = 18;
	localparam int PROD_W = 2 * FIELD_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [FIELD_W-1:0] FIELD_MAX = 18'h3FFFF;
	localparam logic [FIELD_W-1:0] MARGIN_FLOOR_RST = 18'd100;
	localparam logic [FIELD_W-1:0] FULL_SCALE_RST = 18'h3FFFF;
	localparam logic [FIELD_W-1:0] MIN_HEIGHT_RST = 18'd100;

	// floor(x / 10) == (x * 209716) >> 21 for every 18-bit x
	localparam logic [FIELD_W-1:0] MARGIN_RECIP = 18'd209716;
	localparam int RECIP_SHIFT = 21;

	localparam logic [CFG_IDX_W-1:0] REG_MARGIN_FLOOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 2'd2;

	typedef struct packed {
		logic [FIELD_W-1:0] red_sample;
		logic [FIELD_W-1:0] ir_sample;
	} swa_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] axis_low;
		logic [FIELD_W-1:0] axis_high;
		logic [FIELD_W-1:0] window_min;
		logic [FIELD_W-1:0] window_max;
	} swa_out_t;

	typedef struct packed {
		logic load;
		logic write;
		logic read;
		logic [ADDR_W-1:0] addr;
		logic mul;
		logic margin;
		logic axis;
		logic out_load;
	} swa_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] fill_count;
	} swa_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/sliding_window_autoscale_core.sv
// sliding window min/max autoscale core, top level
// result path: the word passes the write, scan, drain, multiply, margin, axis
// and final states, the scan making one ram read per stored pair (1 up to 80)
// a new word is taken only once the sequencer has returned to idle from the last one
// reset: arst_n clears the window pointers, fill count and handshakes and
// loads the register defaults; the window ram needs no clearing pass
// depends on swa_pkg, swa_ctrl, swa_dp and swa_ram
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_autoscale_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// register write port
	input  wire logic                          cfg_we,
	input  wire logic [swa_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [swa_pkg::FIELD_W-1:0]   cfg_wdata,
	// sample word in
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire swa_pkg::swa_in_t              in_data,
	// axis word out
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      swa_pkg::swa_out_t             out_data
);
	import swa_pkg::*;

	swa_cmd_t cmd;
	swa_stat_t stat;

	// sequencer: one word at a time; the output register lets the next
	// word be taken while the previous result waits downstream
	swa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// window ram, ring pointers, scan and axis arithmetic
	swa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

// File: rtl/core/swa_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module swa_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 80
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/swa_ctrl.sv
// sequencer for one word: window write, scan, drain, multiply, margin, axis and output steps
// depends on swa_pkg
`timescale 1ns / 1ps
`default_nettype none
module swa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	output      logic               out_valid,
	input  wire logic               out_ready,
	input  wire swa_pkg::swa_stat_t stat,
	output      swa_pkg::swa_cmd_t  cmd
);
	import swa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_MUL,
		ST_MARGIN,
		ST_AXIS,
		ST_FINAL
	} state_t;

	state_t state_q;
	logic [ADDR_W-1:0] addr_q;
	logic scan_last;
	logic out_free;

	assign scan_last = (CNT_W'(addr_q) == stat.fill_count - CNT_W'(1));
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.addr = addr_q;
		case (state_q)
			ST_IDLE:   cmd.load = in_valid;
			ST_WRITE:  cmd.write = 1'b1;
			ST_SCAN:   cmd.read = 1'b1;
			ST_DRAIN:  cmd.load = 1'b0;
			ST_MUL:    cmd.mul = 1'b1;
			ST_MARGIN: cmd.margin = 1'b1;
			ST_AXIS:   cmd.axis = 1'b1;
			ST_FINAL:  cmd.out_load = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					addr_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				ST_DRAIN:  state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_MARGIN;
				ST_MARGIN: state_q <= ST_AXIS;
				ST_AXIS:   state_q <= ST_FINAL;
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/swa_dp.sv
// datapath: sample window ram, ring pointers, min/max scan, axis arithmetic
// depends on swa_pkg and swa_ram
`timescale 1ns / 1ps
`default_nettype none
module swa_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [swa_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [swa_pkg::FIELD_W-1:0]     cfg_wdata,
	input  wire swa_pkg::swa_in_t                in_data,
	input  wire swa_pkg::swa_cmd_t               cmd,
	output      swa_pkg::swa_stat_t              stat,
	output      swa_pkg::swa_out_t               out_data
);
	import swa_pkg::*;

	logic [FIELD_W-1:0] margin_floor_q, full_scale_q, min_height_q;
	swa_in_t in_q;
	logic [ADDR_W-1:0] slot_q;
	logic [CNT_W-1:0] fill_q;
	logic rd_s1;
	logic [2*FIELD_W-1:0] rd_data;
	logic [FIELD_W-1:0] rd_red, rd_ir;
	logic [FIELD_W-1:0] lo_q, hi_q;
	logic [FIELD_W-1:0] lo_a, lo_b, hi_a, hi_b;
	logic [PROD_W-1:0] prod_q;
	logic [FIELD_W-1:0] quot;
	logic [FIELD_W-1:0] margin_q;
	logic [FIELD_W:0] hi_sum;
	logic [FIELD_W-1:0] axis_lo_q, axis_hi_q;
	logic [FIELD_W:0] forced_sum;
	logic [FIELD_W-1:0] forced_hi;

	swa_ram #(
		.WIDTH(2 * FIELD_W),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(slot_q),
		.wdata({in_q.red_sample, in_q.ir_sample}),
		.re   (cmd.read),
		.raddr(cmd.addr),
		.rdata(rd_data)
	);

	assign stat.fill_count = fill_q;
	assign rd_red = rd_data[2*FIELD_W-1:FIELD_W];
	assign rd_ir = rd_data[FIELD_W-1:0];

	// running extremes over both channels of one stored pair
	assign lo_a = (rd_ir < lo_q) ? rd_ir : lo_q;
	assign lo_b = (rd_red < lo_a) ? rd_red : lo_a;
	assign hi_a = (rd_ir > hi_q) ? rd_ir : hi_q;
	assign hi_b = (rd_red > hi_a) ? rd_red : hi_a;

	assign quot = FIELD_W'(prod_q >> RECIP_SHIFT);
	assign hi_sum = {1'b0, hi_q} + {1'b0, margin_q};
	assign forced_sum = {1'b0, axis_lo_q} + {1'b0, min_height_q};
	assign forced_hi = (forced_sum > {1'b0, FIELD_MAX}) ? FIELD_MAX
		: forced_sum[FIELD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_floor_q <= MARGIN_FLOOR_RST;
			full_scale_q <= FULL_SCALE_RST;
			min_height_q <= MIN_HEIGHT_RST;
			slot_q <= '0;
			fill_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_MARGIN_FLOOR: margin_floor_q <= cfg_wdata;
					REG_FULL_SCALE:   full_scale_q <= cfg_wdata;
					REG_MIN_HEIGHT:   min_height_q <= cfg_wdata;
					default:          ;
				endcase
			end
			if (cmd.write) begin
				slot_q <= (slot_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
					: slot_q + ADDR_W'(1);
				if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			rd_s1 <= cmd.read;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.write) begin
			lo_q <= in_q.ir_sample;
			hi_q <= in_q.ir_sample;
		end else if (rd_s1) begin
			lo_q <= lo_b;
			hi_q <= hi_b;
		end
		if (cmd.mul) begin
			prod_q <= (hi_q - lo_q) * MARGIN_RECIP;
		end
		if (cmd.margin) begin
			margin_q <= (quot < margin_floor_q) ? margin_floor_q : quot;
		end
		if (cmd.axis) begin
			axis_lo_q <= (lo_q > margin_q) ? lo_q - margin_q : '0;
			axis_hi_q <= (hi_sum > {1'b0, full_scale_q}) ? full_scale_q
				: hi_sum[FIELD_W-1:0];
		end
		if (cmd.out_load) begin
			out_data.axis_low <= axis_lo_q;
			out_data.axis_high <= (axis_hi_q <= axis_lo_q) ? forced_hi : axis_hi_q;
			out_data.window_min <= lo_q;
			out_data.window_max <= hi_q;
		end
	end

endmodule
`default_nettype wire

// File: verif/sliding_window_autoscale_core_tb.sv
// self-checking testbench for the sliding window autoscale core
// directed rows and shaped random sample words are checked against a local predictor or a typed value
// depends on swa_pkg and sliding_window_autoscale_core
`timescale 1ns / 1ps
module sliding_window_autoscale_core_tb;
	import swa_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_PAIRS = 1900;
	localparam int IDLE_PERCENT = 36;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 100;
	localparam int REPORT_LIMIT = 10;
	localparam int MARGIN_DIV = 10;
	localparam int QUIET_PHASE = 4;
	// index 3 has no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic [1:0] {
		SIG_NOISE, SIG_PULSE, SIG_EXTREME, SIG_FLAT
	} signal_shape_t;
	typedef enum logic {ROW_PAIR, ROW_WRITE} row_kind_t;

	// one row of the directed table: either a register write or a run of equal sample words
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [FIELD_W-1:0]   reg_val;
		swa_in_t              pair;
		int unsigned          count;
		bit                   typed;
		swa_out_t             want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [FIELD_W-1:0]   cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	swa_in_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	swa_out_t             out_data;

	// local copy of the sample window and the registers
	logic [FIELD_W-1:0] red_hist [WINDOW_DEPTH];
	logic [FIELD_W-1:0] ir_hist [WINDOW_DEPTH];
	int unsigned        hist_fill;
	int unsigned        hist_slot;
	logic [FIELD_W-1:0] floor_reg;
	logic [FIELD_W-1:0] scale_reg;
	logic [FIELD_W-1:0] height_reg;

	swa_out_t    axis_q[$];
	swa_out_t    oldest_axis;
	stim_row_t   directed_rows[$];
	int unsigned mismatches;
	int unsigned pairs_sent;
	int unsigned axes_checked;
	int unsigned reg_writes;
	int unsigned quiet_cycles;
	bit          idle_en;

	sliding_window_autoscale_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// store the pair, rescan the filled part of the window and derive the axis
	function automatic swa_out_t predict_axis(input swa_in_t pair);
		int unsigned lo;
		int unsigned hi;
		int unsigned margin;
		int unsigned a_lo;
		int unsigned a_hi;
		swa_out_t    res;
		red_hist[hist_slot] = pair.red_sample;
		ir_hist[hist_slot] = pair.ir_sample;
		hist_slot = (hist_slot + 1 >= WINDOW_DEPTH) ? 0 : hist_slot + 1;
		if (hist_fill < WINDOW_DEPTH) hist_fill++;
		// scan starts from the new infrared sample, as the block does
		lo = pair.ir_sample;
		hi = pair.ir_sample;
		for (int i = 0; i < hist_fill; i++) begin
			if (ir_hist[i] < lo) lo = ir_hist[i];
			if (red_hist[i] < lo) lo = red_hist[i];
			if (ir_hist[i] > hi) hi = ir_hist[i];
			if (red_hist[i] > hi) hi = red_hist[i];
		end
		// margin is a tenth of the span, held up by the floor register
		margin = (hi - lo) / MARGIN_DIV;
		if (margin < floor_reg) margin = floor_reg;
		a_lo = (lo > margin) ? lo - margin : 0;
		a_hi = hi + margin;
		if (a_hi > scale_reg) a_hi = scale_reg;
		// a collapsed axis is reopened by the minimum height, then kept inside the field
		if (a_hi <= a_lo) a_hi = a_lo + height_reg;
		if (a_hi > FIELD_MAX) a_hi = FIELD_MAX;
		res.axis_low = FIELD_W'(a_lo);
		res.axis_high = FIELD_W'(a_hi);
		res.window_min = FIELD_W'(lo);
		res.window_max = FIELD_W'(hi);
		return res;
	endfunction

	function automatic swa_in_t shape_sample(input signal_shape_t shape,
			input int unsigned base_red, input int unsigned base_ir,
			input int unsigned ripple);
		int unsigned r;
		int unsigned i;
		swa_in_t     pair;
		case (shape)
			SIG_NOISE: begin
				r = $urandom_range(0, FIELD_MAX);
				i = $urandom_range(0, FIELD_MAX);
			end
			SIG_PULSE: begin
				// pulse-like random ripple above a baseline
				r = base_red + $urandom_range(0, ripple);
				i = base_ir + $urandom_range(0, ripple);
				if (r > FIELD_MAX) r = FIELD_MAX;
				if (i > FIELD_MAX) i = FIELD_MAX;
			end
			SIG_EXTREME: begin
				r = $urandom_range(0, 1) ? FIELD_MAX : 0;
				i = $urandom_range(0, 1) ? FIELD_MAX : 0;
			end
			default: begin
				r = base_red;
				i = base_ir;
			end
		endcase
		pair.red_sample = FIELD_W'(r);
		pair.ir_sample = FIELD_W'(i);
		return pair;
	endfunction

	// extremes and small values turn up far more often than a flat draw would give
	function automatic logic [FIELD_W-1:0] pick_reg_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return FIELD_MAX;
			2: return FIELD_W'(1);
			3: return FIELD_W'($urandom_range(0, 3000));
			default: return FIELD_W'($urandom_range(0, FIELD_MAX));
		endcase
	endfunction

	task automatic add_pair(input logic [FIELD_W-1:0] red,
			input logic [FIELD_W-1:0] ir, input int unsigned count);
		directed_rows.push_back('{ROW_PAIR, REG_MARGIN_FLOOR, '0, '{red, ir}, count, 1'b0, '0});
	endtask

	task automatic add_checked(input logic [FIELD_W-1:0] red,
			input logic [FIELD_W-1:0] ir, input swa_out_t want);
		directed_rows.push_back('{ROW_PAIR, REG_MARGIN_FLOOR, '0, '{red, ir}, 1, 1'b1, want});
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
		directed_rows.push_back('{ROW_WRITE, idx, val, '0, 0, 1'b0, '0});
	endtask

	// offer one sample word, with random gaps before it while idling is on
	task automatic send_pair(input swa_in_t pair, input bit typed, input swa_out_t want);
		swa_out_t predicted;
		while (idle_en && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= pair;
		do @(posedge clk); while (!in_ready);
		// predictor always runs so its window tracks the block, typed rows override the value
		predicted = predict_axis(pair);
		axis_q.push_back(typed ? want : predicted);
		pairs_sent++;
	endtask

	// hold the sender off until every outstanding axis word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (axis_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MARGIN_FLOOR: floor_reg = val;
			REG_FULL_SCALE: scale_reg = val;
			REG_MIN_HEIGHT: height_reg = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	// receiver back-pressure, switched off during the quiet stretch
	always @(posedge clk) begin
		out_ready <= idle_en ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
	end

	// every accepted axis word is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (axis_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected axis word low=%0d high=%0d min=%0d max=%0d",
						out_data.axis_low, out_data.axis_high, out_data.window_min,
						out_data.window_max);
			end else begin
				oldest_axis = axis_q.pop_front();
				axes_checked++;
				if (out_data.axis_low !== oldest_axis.axis_low
						|| out_data.axis_high !== oldest_axis.axis_high
						|| out_data.window_min !== oldest_axis.window_min
						|| out_data.window_max !== oldest_axis.window_max) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("axis word %0d: expected low=%0d high=%0d min=%0d max=%0d",
							axes_checked, oldest_axis.axis_low, oldest_axis.axis_high,
							oldest_axis.window_min, oldest_axis.window_max,
							", got low=%0d high=%0d min=%0d max=%0d",
							out_data.axis_low, out_data.axis_high, out_data.window_min,
							out_data.window_max);
				end
			end
		end
	end

	// watchdog: a healthy run moves a word well within the limit even with a full window
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		signal_shape_t shape;
		int unsigned   base_red;
		int unsigned   base_ir;
		int unsigned   ripple;
		int unsigned   seg_len;
		int unsigned   random_sent;
		int unsigned   phase;
		int unsigned   n_writes;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_MARGIN_FLOOR;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		idle_en = 1'b1;
		mismatches = 0;
		pairs_sent = 0;
		axes_checked = 0;
		reg_writes = 0;
		quiet_cycles = 0;
		random_sent = 0;
		phase = 0;

		// predictor at its reset state
		hist_fill = 0;
		hist_slot = 0;
		floor_reg = MARGIN_FLOOR_RST;
		scale_reg = FULL_SCALE_RST;
		height_reg = MIN_HEIGHT_RST;

		// directed table
		// first word alone in the window: zero span, floor margin only
		add_checked('0, '0, '{18'd0, 18'd100, 18'd0, 18'd0});
		// full span: high end saturates at full scale
		add_checked(FIELD_MAX, FIELD_MAX, '{18'd0, FIELD_MAX, 18'd0, FIELD_MAX});
		add_pair(18'h2AAAA, 18'h15555, 1);
		add_pair(18'h15555, 18'h2AAAA, 1);
		// push a whole window of high samples so the ring wraps and the minimum rises
		add_pair(FIELD_MAX, 18'h3FFF0, WINDOW_DEPTH);
		// collapsed axis reopened by the minimum height, which runs past the field
		add_write(REG_FULL_SCALE, 18'd1);
		add_write(REG_MIN_HEIGHT, 18'd200);
		add_checked(18'h3FFF8, 18'h3FFF0, '{18'd262028, FIELD_MAX, 18'd262128, 18'd262143});
		// zero minimum height leaves high equal to low
		add_write(REG_MIN_HEIGHT, '0);
		add_checked(18'h3FFF0, FIELD_MAX, '{18'd262028, 18'd262028, 18'd262128, 18'd262143});
		// zero full scale
		add_write(REG_FULL_SCALE, '0);
		add_pair(FIELD_MAX, FIELD_MAX, 1);
		// no margin floor at all, then the largest one
		add_write(REG_MARGIN_FLOOR, '0);
		add_pair(18'h3FFF5, 18'h3FFFA, 1);
		add_write(REG_MARGIN_FLOOR, FIELD_MAX);
		add_pair('0, FIELD_MAX, 1);
		// a write to the spare index must change nothing
		add_write(REG_SPARE, FIELD_MAX);
		add_pair(18'd12345, 18'd0, 1);
		add_write(REG_MARGIN_FLOOR, MARGIN_FLOOR_RST);
		add_write(REG_FULL_SCALE, FULL_SCALE_RST);
		add_write(REG_MIN_HEIGHT, MIN_HEIGHT_RST);
		add_pair(18'h20000, 18'h1FFFF, 1);
		add_pair(18'd1, 18'd2, 1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				drain_results();
				write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
			end else begin
				repeat (directed_rows[r].count)
					send_pair(directed_rows[r].pair, directed_rows[r].typed,
						directed_rows[r].want);
			end
		end

		// random phases: registers change only once the block has gone idle
		while (random_sent < RANDOM_PAIRS) begin
			drain_results();
			if (phase % 3 == 0) begin
				// back to the defaults now and then so ordinary behaviour dominates
				write_reg(REG_MARGIN_FLOOR, MARGIN_FLOOR_RST);
				write_reg(REG_FULL_SCALE, FULL_SCALE_RST);
				write_reg(REG_MIN_HEIGHT, MIN_HEIGHT_RST);
			end else begin
				n_writes = $urandom_range(0, 3);
				repeat (n_writes)
					write_reg(CFG_IDX_W'($urandom_range(0, 3)), pick_reg_value());
			end

			// one long stretch with no idling on either side
			idle_en = (phase != QUIET_PHASE);
			seg_len = (phase == QUIET_PHASE) ? 400 : $urandom_range(40, 250);

			// mostly pulse-like traces, the rest noise, rail hits and flat lines
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: shape = SIG_PULSE;
				5, 6: shape = SIG_NOISE;
				7: shape = SIG_EXTREME;
				default: shape = SIG_FLAT;
			endcase
			base_red = $urandom_range(0, FIELD_MAX);
			base_ir = $urandom_range(0, 1) ? base_red : $urandom_range(0, FIELD_MAX);
			ripple = $urandom_range(0, 4000);

			for (int k = 0; k < seg_len && random_sent < RANDOM_PAIRS; k++) begin
				send_pair(shape_sample(shape, base_red, base_ir, ripple), 1'b0, '0);
				random_sent++;
			end
			phase++;
		end

		idle_en = 1'b1;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d directed rows and %0d random sample words over %0d phases",
			directed_rows.size(), random_sent, phase);
		$display("%0d sample words sent, %0d axis words checked, %0d register writes",
			pairs_sent, axes_checked, reg_writes);
		if (mismatches == 0 && axis_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d axis words outstanding", mismatches, axis_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/swa_pkg.sv
rtl/core/swa_ram.sv
rtl/core/swa_ctrl.sv
rtl/core/swa_dp.sv
rtl/core/sliding_window_autoscale_core.sv
verif/sliding_window_autoscale_core_tb.sv
